/* src/three_band_biquad_equalizer_macros.svh */
// assertion macros used by the equalizer checker
`ifndef THREE_BAND_BIQUAD_EQUALIZER_MACROS_SVH
`define THREE_BAND_BIQUAD_EQUALIZER_MACROS_SVH

// property must hold at every clock edge outside reset
`define TBBEQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: property violated");

// expression must never be true outside reset
`define TBBEQ_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

/* src/tbbeq_pkg.sv */
// shared constants, types and codes of the three-band equalizer
`default_nettype none

package tbbeq_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 24;
  localparam int COEFF_WIDTH_DEF     = 20;
  localparam int COEFF_FRAC_BITS_DEF = 16;

  localparam int NUM_SECTIONS = 3;
  localparam int NUM_TAPS     = 5;
  localparam int NUM_REGS     = 2 * NUM_SECTIONS;
  localparam int REG_IDX_W    = 3;
  localparam int ACC_WIDTH    = 64;
  localparam int SEC_W        = $clog2(NUM_SECTIONS);
  localparam int STEP_W       = $clog2(NUM_TAPS + 1);

  // multiply-accumulate tap order within one section
  typedef enum logic [2:0] {
    TAP_B0,
    TAP_B1,
    TAP_B2,
    TAP_A1,
    TAP_A2
  } tap_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_OUT
  } state_e;

  // sequencer to datapath control
  typedef struct packed {
    logic load;
    logic issue;
    tap_e tap;
    logic acc_en;
    logic round;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* src/tbbeq_if.sv */
// valid/ready stream interfaces for input and result items
`default_nettype none

interface tbbeq_in_if
  import tbbeq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface tbbeq_out_if
  import tbbeq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

/* src/tbbeq_ring.sv */
// coefficient registers and sample history, rotated so section in use sits at slot 0
`default_nettype none

module tbbeq_ring
  import tbbeq_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int COEFF_WIDTH     = COEFF_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [REG_IDX_W-1:0]           cfg_idx_i,
  input  logic [3*COEFF_WIDTH-1:0]       cfg_data_i,
  input  mac_ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sec_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sec_out_i,
  output logic signed [COEFF_WIDTH-1:0]  b0_o,
  output logic signed [COEFF_WIDTH-1:0]  b1_o,
  output logic signed [COEFF_WIDTH-1:0]  b2_o,
  output logic signed [COEFF_WIDTH-1:0]  a1_o,
  output logic signed [COEFF_WIDTH-1:0]  a2_o,
  output logic signed [SAMPLE_WIDTH-1:0] x1_o,
  output logic signed [SAMPLE_WIDTH-1:0] x2_o,
  output logic signed [SAMPLE_WIDTH-1:0] y1_o,
  output logic signed [SAMPLE_WIDTH-1:0] y2_o
);

  localparam int FF_W    = 3 * COEFF_WIDTH;
  localparam int FB_W    = 2 * COEFF_WIDTH;
  localparam int FF_KEEP = (FF_W > ACC_WIDTH) ? ACC_WIDTH : FF_W;
  // bits past the 64-bit register boundary always read as zero
  localparam logic [FF_W-1:0] FF_MASK = {FF_W{1'b1}} >> (FF_W - FF_KEEP);
  localparam logic [COEFF_WIDTH-1:0] COEFF_ONE =
    COEFF_WIDTH'(64'd1 << COEFF_FRAC_BITS);

  logic [FF_W-1:0] ff_q [NUM_SECTIONS];
  logic [FB_W-1:0] fb_q [NUM_SECTIONS];
  logic signed [SAMPLE_WIDTH-1:0] x1_q [NUM_SECTIONS];
  logic signed [SAMPLE_WIDTH-1:0] x2_q [NUM_SECTIONS];
  logic signed [SAMPLE_WIDTH-1:0] y1_q [NUM_SECTIONS];
  logic signed [SAMPLE_WIDTH-1:0] y2_q [NUM_SECTIONS];

  logic             cfg_hit;
  logic [SEC_W-1:0] cfg_slot;

  assign cfg_hit  = cfg_we_i && (cfg_idx_i < REG_IDX_W'(NUM_REGS));
  assign cfg_slot = cfg_idx_i[SEC_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        ff_q[i] <= FF_W'(COEFF_ONE);
        fb_q[i] <= '0;
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (cfg_hit) begin
      if (cfg_idx_i[0]) begin
        fb_q[cfg_slot] <= cfg_data_i[FB_W-1:0];
      end else begin
        ff_q[cfg_slot] <= cfg_data_i & FF_MASK;
      end
    end else if (ctrl_i.round) begin
      // rotate by one section, finished section goes to the back
      for (int i = 0; i < NUM_SECTIONS - 1; i++) begin
        ff_q[i] <= ff_q[i+1];
        fb_q[i] <= fb_q[i+1];
        x1_q[i] <= x1_q[i+1];
        x2_q[i] <= x2_q[i+1];
        y1_q[i] <= y1_q[i+1];
        y2_q[i] <= y2_q[i+1];
      end
      ff_q[NUM_SECTIONS-1] <= ff_q[0];
      fb_q[NUM_SECTIONS-1] <= fb_q[0];
      x1_q[NUM_SECTIONS-1] <= sec_in_i;
      x2_q[NUM_SECTIONS-1] <= x1_q[0];
      y1_q[NUM_SECTIONS-1] <= sec_out_i;
      y2_q[NUM_SECTIONS-1] <= y1_q[0];
    end
  end

  assign b0_o = ff_q[0][COEFF_WIDTH-1:0];
  assign b1_o = ff_q[0][2*COEFF_WIDTH-1:COEFF_WIDTH];
  assign b2_o = ff_q[0][3*COEFF_WIDTH-1:2*COEFF_WIDTH];
  assign a1_o = fb_q[0][COEFF_WIDTH-1:0];
  assign a2_o = fb_q[0][2*COEFF_WIDTH-1:COEFF_WIDTH];
  assign x1_o = x1_q[0];
  assign x2_o = x2_q[0];
  assign y1_o = y1_q[0];
  assign y2_o = y2_q[0];

endmodule

`default_nettype wire

/* src/tbbeq_mac.sv */
// shared multiply-accumulate unit with round and saturate
`default_nettype none

module tbbeq_mac
  import tbbeq_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int COEFF_WIDTH     = COEFF_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  mac_ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic signed [COEFF_WIDTH-1:0]  b0_i,
  input  logic signed [COEFF_WIDTH-1:0]  b1_i,
  input  logic signed [COEFF_WIDTH-1:0]  b2_i,
  input  logic signed [COEFF_WIDTH-1:0]  a1_i,
  input  logic signed [COEFF_WIDTH-1:0]  a2_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x1_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x2_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y1_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y2_i,
  output logic signed [SAMPLE_WIDTH-1:0] sec_in_o,
  output logic signed [SAMPLE_WIDTH-1:0] sec_out_o
);

  localparam int PROD_W = COEFF_WIDTH + SAMPLE_WIDTH;
  localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
    (ACC_WIDTH'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_WIDTH'(1);
  localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);
  localparam logic signed [ACC_WIDTH-1:0] RND_HALF =
    ACC_WIDTH'(1) <<< (COEFF_FRAC_BITS - 1);

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [ACC_WIDTH-1:0]    acc_q, acc_d;
  logic signed [ACC_WIDTH-1:0]    prod_q;
  logic                           sub_q;

  logic signed [COEFF_WIDTH-1:0]  coef;
  logic signed [SAMPLE_WIDTH-1:0] opnd;
  logic                           sel_sub;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_WIDTH-1:0]    rnd, shifted;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  // operand select for the tap being issued
  always_comb begin
    case (ctrl_i.tap)
      TAP_B0: begin coef = b0_i; opnd = x_q;  sel_sub = 1'b0; end
      TAP_B1: begin coef = b1_i; opnd = x1_i; sel_sub = 1'b0; end
      TAP_B2: begin coef = b2_i; opnd = x2_i; sel_sub = 1'b0; end
      TAP_A1: begin coef = a1_i; opnd = y1_i; sel_sub = 1'b1; end
      TAP_A2: begin coef = a2_i; opnd = y2_i; sel_sub = 1'b1; end
      default: begin coef = '0; opnd = '0; sel_sub = 1'b0; end
    endcase
  end

  assign prod  = coef * opnd;
  assign acc_d = sub_q ? (acc_q - prod_q) : (acc_q + prod_q);

  // round half up, then clamp to the sample range
  always_comb begin
    rnd     = acc_q + RND_HALF;
    shifted = rnd >>> COEFF_FRAC_BITS;
    if (shifted > SAT_HI) begin
      y_sat = SAMPLE_WIDTH'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      y_sat = SAMPLE_WIDTH'(SAT_LO);
    end else begin
      y_sat = SAMPLE_WIDTH'(shifted);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= ACC_WIDTH'(prod);
      sub_q  <= sel_sub;
    end
    if (ctrl_i.load || ctrl_i.round) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.load) begin
      x_q <= in_sample_i;
    end else if (ctrl_i.round) begin
      x_q <= y_sat;
    end
  end

  assign sec_in_o  = x_q;
  assign sec_out_o = y_sat;

endmodule

`default_nettype wire

/* src/tbbeq_ctrl.sv */
// sequencer stepping the shared unit through taps and sections
`default_nettype none

module tbbeq_ctrl
  import tbbeq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mac_ctrl_t ctrl_o
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_TAPS);
  localparam logic [SEC_W-1:0]  LAST_SEC  = SEC_W'(NUM_SECTIONS - 1);

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [SEC_W-1:0]    sec_q, sec_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sec_q   <= sec_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sec_d       = sec_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl_o      = '{load: 1'b0, issue: 1'b0, tap: TAP_B0, acc_en: 1'b0, round: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          step_d      = '0;
          sec_d       = '0;
          state_d     = ST_MAC;
        end
      end
      ST_MAC: begin
        // accumulate takes each product in the cycle after its issue, through the product register
        ctrl_o.issue  = (step_q != LAST_STEP);
        ctrl_o.tap    = tap_e'(step_q);
        ctrl_o.acc_en = (step_q != '0);
        step_d        = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctrl_o.round = 1'b1;
        if (sec_q == LAST_SEC) begin
          sec_d   = '0;
          state_d = ST_OUT;
        end else begin
          sec_d   = sec_q + SEC_W'(1);
          state_d = ST_MAC;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/three_band_biquad_equalizer.sv */
// top level of the three-band cascaded biquad equalizer
// one item in flight: the input closes once an item is taken and reopens after the
//   result is taken; the single shared multiplier does 5 taps plus a drain step and
//   a round step per section, over 3 sections, between the idle and out states
// reset: rst_ni asynchronous active low clears history, sequencer and coefficients
//   (b0 = 1.0, all others 0); no clearing pass, ready right after reset
`default_nettype none

module three_band_biquad_equalizer
  import tbbeq_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int COEFF_WIDTH     = COEFF_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tbbeq_in_if.sink                 in_i,
  tbbeq_out_if.source              out_o,
  input  logic                     cfg_we_i,
  input  logic [REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [3*COEFF_WIDTH-1:0] cfg_data_i
);

  // control from the sequencer to the datapath and ring
  mac_ctrl_t ctrl;

  // coefficients and history of the section now being computed
  logic signed [COEFF_WIDTH-1:0]  b0, b1, b2, a1, a2;
  logic signed [SAMPLE_WIDTH-1:0] x1, x2, y1, y2;

  // section input (also final result after the last section) and rounded output
  logic signed [SAMPLE_WIDTH-1:0] sec_in, sec_out;

  // sequencer: idle -> 3 sections of (5 taps plus drain, then round) -> hold result until taken
  tbbeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  // coefficient registers and history; rotates one section per round cycle,
  // three rotations per item bring it back to register order for config writes
  tbbeq_ring #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .COEFF_WIDTH     (COEFF_WIDTH),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .sec_in_i   (sec_in),
    .sec_out_i  (sec_out),
    .b0_o       (b0),
    .b1_o       (b1),
    .b2_o       (b2),
    .a1_o       (a1),
    .a2_o       (a2),
    .x1_o       (x1),
    .x2_o       (x2),
    .y1_o       (y1),
    .y2_o       (y2)
  );

  // single multiplier with a 64-bit wrapping accumulator
  tbbeq_mac #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .COEFF_WIDTH     (COEFF_WIDTH),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .in_sample_i (in_i.in_sample),
    .b0_i        (b0),
    .b1_i        (b1),
    .b2_i        (b2),
    .a1_i        (a1),
    .a2_i        (a2),
    .x1_i        (x1),
    .x2_i        (x2),
    .y1_i        (y1),
    .y2_i        (y2),
    .sec_in_o    (sec_in),
    .sec_out_o   (sec_out)
  );

  // after the last round the section-input register holds the result item
  assign out_o.out_sample = sec_in;

endmodule

`default_nettype wire

/* src/tbbeq_checker.sv */
// port-level assertions for the equalizer and their bind
`default_nettype none
`include "three_band_biquad_equalizer_macros.svh"

module tbbeq_checker
  import tbbeq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] out_sample_i
);

  // one item in flight: taking an item closes the input
  `TBBEQ_ASSERT(busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)
  // a result never shows up the cycle after an item is taken
  `TBBEQ_ASSERT(no_instant_result, clk_i, rst_ni, in_valid_i && in_ready_i |=> !out_valid_i)
  // input stays closed while a result waits
  `TBBEQ_NEVER(no_overlap, clk_i, rst_ni, out_valid_i && in_ready_i)
  // stalled result holds
  `TBBEQ_ASSERT(out_hold, clk_i, rst_ni,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))

endmodule

bind three_band_biquad_equalizer tbbeq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tbbeq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.out_sample)
);

`default_nettype wire
